// ===== hdl/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// Holds action and result codes, the code table entry and the result record.
// No dependencies.
package hcbp_pkg;

  localparam int WORD_BITS = 32;
  localparam int CODE_BITS = 32;
  localparam int SYMBOLS   = 256;
  localparam int SYM_W     = 8;
  localparam int LEN_W     = 6;
  localparam int CNT_W     = 5;

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CODE_BITS < WORD_BITS ? CODE_BITS : WORD_BITS);

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_TOTAL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [CODE_BITS-1:0] word;
    logic [LEN_W-1:0]     len;
  } entry_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [WORD_BITS-1:0] packed_word;
    logic [31:0]          bit_total;
    logic                 last;
  } result_t;

endpackage

// ===== hdl/hcbp_out_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle.
// Depends on hcbp_pkg for the result record.
module hcbp_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_num,
  input  hcbp_pkg::result_t push_a,
  input  hcbp_pkg::result_t push_b,
  input  logic             pop,
  output logic             room2,
  output logic             not_empty,
  output hcbp_pkg::result_t head
);

  hcbp_pkg::result_t mem [4];
  logic [1:0] rd_ptr_r, wr_ptr_r;
  logic [2:0] level_r, level_nxt;

  assign not_empty = (level_r != 3'd0);
  assign room2     = (level_r <= 3'd2);
  assign head      = mem[rd_ptr_r];
  assign level_nxt = level_r + {1'b0, push_num} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 2'd0;
      wr_ptr_r <= 2'd0;
      level_r  <= 3'd0;
    end else begin
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      wr_ptr_r <= wr_ptr_r + push_num;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem[wr_ptr_r] <= push_a;
    end
    if (push_num == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= push_b;
    end
  end

endmodule

// ===== hdl/huffman_code_bit_packer_unit.sv =====
// Top level of the Huffman code bit packer.
// Depends on hcbp_pkg and hcbp_out_fifo.
//
// The unit takes one item per cycle while in_stall is low. Each item's code table read is
// registered into the stage-1 register at the transfer; the packer consumes it once the
// queue has two free entries. Results pass through a four-entry queue. A flush produces
// one or two results, and the input stalls while a stage-1 item waits for that room.
// The table has a valid bit per entry, so no clearing pass follows reset.
module huffman_code_bit_packer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_word,
  input  logic [5:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_packed_word,
  output logic [31:0] out_bit_total,
  output logic        out_last
);

  hcbp_pkg::entry_t tab_mem [hcbp_pkg::SYMBOLS];
  logic [hcbp_pkg::SYMBOLS-1:0] tab_vld_r;

  logic                             in_acc;
  logic                             s1_valid_r;
  logic [1:0]                       s1_action_r;
  hcbp_pkg::entry_t                 s1_ent_r;
  logic                             s1_hit_r;
  logic                             s1_adv;

  logic [hcbp_pkg::WORD_BITS-1:0]   pend_r, pend_nxt;
  logic [hcbp_pkg::CNT_W-1:0]       pend_cnt_r, pend_cnt_nxt;
  logic [31:0]                      total_r, total_nxt;

  logic [hcbp_pkg::LEN_W-1:0]       ld_len;
  logic [hcbp_pkg::CODE_BITS-1:0]   ld_mask;
  logic [hcbp_pkg::LEN_W-1:0]       n, space, rem, pad;
  logic [32:0]                      sum;
  logic [1:0]                       push_num;
  hcbp_pkg::result_t                push_a, push_b, head;
  logic                             room2, pop;

  assign in_stall = s1_valid_r && !room2;
  assign in_acc   = in_valid && !in_stall;
  assign s1_adv   = s1_valid_r && room2;

  assign ld_len  = (in_code_length > hcbp_pkg::LEN_CAP) ? hcbp_pkg::LEN_CAP : in_code_length;
  assign ld_mask = (ld_len >= hcbp_pkg::LEN_W'(hcbp_pkg::CODE_BITS)) ? '1 : ~('1 << ld_len);

  always_ff @(posedge clk) begin
    if (in_acc && in_action == hcbp_pkg::ACT_LOAD) begin
      tab_mem[in_symbol] <= '{word: in_code_word & ld_mask, len: ld_len};
    end
    if (in_acc) begin
      s1_ent_r    <= tab_mem[in_symbol];
      s1_hit_r    <= tab_vld_r[in_symbol];
      s1_action_r <= in_action;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_vld_r  <= '0;
      s1_valid_r <= 1'b0;
      pend_r     <= '0;
      pend_cnt_r <= '0;
      total_r    <= '0;
    end else begin
      if (in_acc && in_action == hcbp_pkg::ACT_LOAD) begin
        tab_vld_r[in_symbol] <= 1'b1;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      pend_r     <= pend_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      total_r    <= total_nxt;
    end
  end

  assign n     = s1_hit_r ? s1_ent_r.len : '0;
  assign space = hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS) - {1'b0, pend_cnt_r};
  assign rem   = n - space;
  assign pad   = space;
  assign sum   = {1'b0, total_r} + {27'd0, n};

  always_comb begin
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    total_nxt    = total_r;
    push_num     = 2'd0;
    push_a       = '{kind: hcbp_pkg::KIND_WORD, packed_word: '0, bit_total: '0, last: 1'b0};
    push_b       = push_a;
    if (s1_adv) begin
      case (s1_action_r)
        hcbp_pkg::ACT_ENCODE: begin
          if (n == '0) begin
            push_num    = 2'd1;
            push_a.kind = hcbp_pkg::KIND_ERROR;
          end else begin
            total_nxt = sum[32] ? '1 : sum[31:0];
            if (n < space) begin
              pend_nxt     = (pend_r << n) | s1_ent_r.word;
              pend_cnt_nxt = pend_cnt_r + n[hcbp_pkg::CNT_W-1:0];
            end else begin
              push_num           = 2'd1;
              push_a.packed_word = (pend_r << space) | (s1_ent_r.word >> rem);
              pend_nxt           = s1_ent_r.word & ~('1 << rem);
              pend_cnt_nxt       = rem[hcbp_pkg::CNT_W-1:0];
            end
          end
        end
        hcbp_pkg::ACT_FLUSH: begin
          if (pend_cnt_r != '0) begin
            push_num           = 2'd2;
            push_a.packed_word = pend_r << pad;
            push_b.kind        = hcbp_pkg::KIND_TOTAL;
            push_b.bit_total   = total_r;
            push_b.last        = 1'b1;
          end else begin
            push_num         = 2'd1;
            push_a.kind      = hcbp_pkg::KIND_TOTAL;
            push_a.bit_total = total_r;
            push_a.last      = 1'b1;
          end
          pend_nxt     = '0;
          pend_cnt_nxt = '0;
          total_nxt    = '0;
        end
        default: begin
          push_num = 2'd0;
        end
      endcase
    end
  end

  assign pop = out_valid && !out_stall;

  hcbp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push_a    (push_a),
    .push_b    (push_b),
    .pop       (pop),
    .room2     (room2),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_kind        = head.kind;
  assign out_packed_word = head.packed_word;
  assign out_bit_total   = head.bit_total;
  assign out_last        = head.last;

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == hcbp_pkg::ACT_FLUSH) |=> (pend_cnt_r == '0 && total_r == '0))
    else $error("packer state not cleared after flush");

  a_last_is_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind == hcbp_pkg::KIND_TOTAL))
    else $error("last flag on a result that is not a bit count");

  a_word_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != hcbp_pkg::KIND_WORD) |-> (out_packed_word == '0))
    else $error("packed word data on a non-word result");

endmodule

// ===== dv/hcbp_checker.sv =====
// Checker for the Huffman code bit packer: watches both channels, predicts every result
// from its own copy of the code table and packer, and compares in order.
// Depends on hcbp_pkg for the action and result codes and the result record.
module hcbp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_word,
  input  logic [5:0]  in_code_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_packed_word,
  input  logic [31:0] out_bit_total,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [hcbp_pkg::CODE_BITS-1:0] code_words [hcbp_pkg::SYMBOLS];
  logic [hcbp_pkg::LEN_W-1:0]     code_lens  [hcbp_pkg::SYMBOLS];
  logic [hcbp_pkg::WORD_BITS-1:0] held_bits;
  int unsigned                    held_count;
  logic [31:0]                    message_bits;
  hcbp_pkg::result_t              expected_q [$];
  hcbp_pkg::result_t              want;

  function automatic logic [31:0] low_mask(input int unsigned w);
    if (w >= 32) return '1;
    return (32'd1 << w) - 32'd1;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
    $display("%0t ns mismatch on %s: got %h, predicted %h", $time, what, got, exp_val);
    fail_count++;
  endtask

  task automatic queue_result(input hcbp_pkg::result_t r);
    expected_q = {expected_q, r};
  endtask

  task automatic pack_item(input logic [1:0] action, input logic [7:0] sym,
                           input logic [31:0] cw, input logic [5:0] len);
    logic [5:0]        n;
    logic [63:0]       merged;
    int unsigned       space;
    int unsigned       rem;
    hcbp_pkg::result_t r;
    r = '0;
    case (action)
      hcbp_pkg::ACT_LOAD: begin
        n = (len > hcbp_pkg::LEN_CAP) ? hcbp_pkg::LEN_CAP : len;
        code_lens[sym]  = n;
        code_words[sym] = cw & low_mask({26'd0, n});
      end
      hcbp_pkg::ACT_ENCODE: begin
        if (code_lens[sym] == '0) begin
          r.kind = hcbp_pkg::KIND_ERROR;
          queue_result(r);
        end else begin
          n = code_lens[sym];
          if (message_bits > 32'hFFFF_FFFF - 32'(n)) message_bits = '1;
          else message_bits = message_bits + 32'(n);
          space = hcbp_pkg::WORD_BITS - held_count;
          if (n < space) begin
            held_bits  = (held_bits << n) | code_words[sym];
            held_count = held_count + n;
          end else begin
            rem    = n - space;
            merged = ({32'd0, held_bits} << space) | ({32'd0, code_words[sym]} >> rem);
            held_bits     = code_words[sym] & low_mask(rem);
            held_count    = rem;
            r.kind        = hcbp_pkg::KIND_WORD;
            r.packed_word = merged[31:0];
            queue_result(r);
          end
        end
      end
      hcbp_pkg::ACT_FLUSH: begin
        if (held_count != 0) begin
          merged        = {32'd0, held_bits} << (hcbp_pkg::WORD_BITS - held_count);
          r.kind        = hcbp_pkg::KIND_WORD;
          r.packed_word = merged[31:0];
          queue_result(r);
          r = '0;
        end
        r.kind      = hcbp_pkg::KIND_TOTAL;
        r.bit_total = message_bits;
        r.last      = 1'b1;
        queue_result(r);
        held_bits    = '0;
        held_count   = 0;
        message_bits = '0;
      end
      default: begin
      end
    endcase
  endtask

  // A result leaves only after its input transfer has passed the stage-1 register and the queue, so the output side
  // is checked before the input side of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (code_lens[i]) begin
        code_lens[i]  = '0;
        code_words[i] = '0;
      end
      held_bits    = '0;
      held_count   = 0;
      message_bits = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("result with nothing predicted (kind)", 32'(out_kind), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_kind !== want.kind) report("kind", 32'(out_kind), 32'(want.kind));
          if (out_packed_word !== want.packed_word) begin
            report("packed_word", out_packed_word, want.packed_word);
          end
          if (out_bit_total !== want.bit_total) begin
            report("bit_total", out_bit_total, want.bit_total);
          end
          if (out_last !== want.last) report("last", 32'(out_last), 32'(want.last));
        end
      end
      if (in_valid && !in_stall) begin
        pack_item(in_action, in_symbol, in_code_word, in_code_length);
      end
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== dv/huffman_code_bit_packer_unit_test.sv =====
// Testbench top for the Huffman code bit packer: clock, reset, directed and random
// stimulus with bursty input and patterned output stall, and the final verdict.
// Depends on hcbp_pkg, huffman_code_bit_packer_unit and hcbp_checker.
module huffman_code_bit_packer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action      = '0;
  logic [7:0]  in_symbol      = '0;
  logic [31:0] in_code_word   = '0;
  logic [5:0]  in_code_length = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_packed_word;
  logic [31:0] out_bit_total;
  logic        out_last;

  int fail_count;
  int pending_results;
  int items_sent;
  int burst_left;
  bit hold_go;
  bit mapped [hcbp_pkg::SYMBOLS];

  huffman_code_bit_packer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_symbol       (in_symbol),
    .in_code_word    (in_code_word),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_packed_word (out_packed_word),
    .out_bit_total   (out_bit_total),
    .out_last        (out_last)
  );

  hcbp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_symbol       (in_symbol),
    .in_code_word    (in_code_word),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_packed_word (out_packed_word),
    .out_bit_total   (out_bit_total),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
  endtask

  task automatic send(input logic [1:0] action, input logic [7:0] sym,
                      input logic [31:0] cw, input logic [5:0] len);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_action      <= action;
    in_symbol      <= sym;
    in_code_word   <= cw;
    in_code_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (action == hcbp_pkg::ACT_LOAD) mapped[sym] = (len != '0);
    if (action != ACT_UNUSED) items_sent++;
    pace();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic load_random();
    logic [7:0] sym;
    logic [5:0] len;
    sym = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = 6'($urandom_range(33, 63));
      2, 3:    len = 6'($urandom_range(1, 4));
      4:       len = 6'd32;
      default: len = 6'($urandom_range(1, 31));
    endcase
    send(hcbp_pkg::ACT_LOAD, sym, $urandom, len);
  endtask

  function automatic logic [7:0] pick_mapped();
    logic [7:0] sym;
    sym = '0;
    for (int i = 0; i < 8; i++) begin
      sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 31));
      if (mapped[sym]) return sym;
    end
    return sym;
  endfunction

  task automatic random_message();
    int enc_count;
    enc_count = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    for (int i = 0; i < enc_count; i++) begin
      case ($urandom_range(0, 19))
        0, 1:    load_random();
        2:       send(ACT_UNUSED, 8'($urandom), $urandom, 6'($urandom));
        3:       send(hcbp_pkg::ACT_ENCODE, 8'($urandom_range(0, 255)), $urandom,
                      6'($urandom));
        default: send(hcbp_pkg::ACT_ENCODE, pick_mapped(), $urandom, 6'($urandom));
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      send(hcbp_pkg::ACT_FLUSH, 8'($urandom), $urandom, 6'($urandom));
    end
  endtask

  initial begin : receiver
    int mode;
    int left;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_go = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 128);
      end
      left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    bit held;
    bit paused;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send(hcbp_pkg::ACT_ENCODE, 8'h00, '0, '0);
    send(hcbp_pkg::ACT_FLUSH, 8'h00, '0, '0);
    send(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send(hcbp_pkg::ACT_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send(hcbp_pkg::ACT_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1);
    send(hcbp_pkg::ACT_LOAD, 8'h01, 32'hA5A5_A5A5, 6'd63);
    send(hcbp_pkg::ACT_LOAD, 8'h02, 32'h1234_5678, 6'd0);
    send(hcbp_pkg::ACT_ENCODE, 8'hFF, '0, '0);
    send(hcbp_pkg::ACT_ENCODE, 8'h00, '0, '0);
    send(hcbp_pkg::ACT_ENCODE, 8'h01, '0, '0);
    send(hcbp_pkg::ACT_ENCODE, 8'h02, '0, '0);
    send(hcbp_pkg::ACT_FLUSH, 8'h00, '0, '0);
    send(hcbp_pkg::ACT_LOAD, 8'h80, 32'h5555_5555, 6'd31);
    send(hcbp_pkg::ACT_ENCODE, 8'h80, '0, '0);
    send(hcbp_pkg::ACT_ENCODE, 8'h00, '0, '0);
    send(hcbp_pkg::ACT_FLUSH, 8'h00, '0, '0);
    send(hcbp_pkg::ACT_LOAD, 8'h03, 32'hFFFF_FFE0, 6'd5);
    repeat (7) send(hcbp_pkg::ACT_ENCODE, 8'h03, '0, '0);
    send(hcbp_pkg::ACT_FLUSH, 8'h00, '0, '0);

    repeat (32) load_random();
    while (items_sent < 1450) begin
      random_message();
      if (!held && items_sent > 500) begin
        held    = 1'b1;
        hold_go = 1'b1;
      end
      if (!paused && items_sent > 1000) begin
        paused = 1'b1;
        wait_idle();
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
